>>> rtl/lay_pkg.sv
// Shared types, constants and the arctangent table for the look-at angle pipeline.
// No dependencies; used by every module under rtl.
package lay_pkg;

    localparam int COORD_W = 32;               // Q16.16 coordinate width
    localparam int DIFF_W  = COORD_W + 1;      // exact difference
    localparam int NORM_W  = COORD_W + 2;      // normalized difference
    localparam int CRD_W   = 38;               // CORDIC datapath, covers gain growth
    localparam int ACC_W   = 32;               // turn accumulator, 2^-32 turn
    localparam int ANG_W   = 16;
    localparam int PROD_W  = 64;
    localparam int GAIN_SHIFT = 28;

    localparam logic [ANG_W-1:0] TURN_1Q = 16'd16384;
    localparam logic [ANG_W-1:0] TURN_3Q = 16'd49152;
    localparam logic [ACC_W-1:0] TURN_HALF = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ROUND_HALF = 32'h0000_8000;
    localparam logic [28:0] GAIN_Q28 = 29'd442048841;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

    typedef struct packed {
        logic vert;     // dx and dz both zero
        logic dy_pos;
        logic zero;     // whole vector zero
    } t_flags;

    typedef struct packed {
        logic signed [CRD_W-1:0] pitch_y;
        t_flags                  flags;
    } t_yaw_sb;

    typedef struct packed {
        logic [ACC_W-1:0] yaw_acc;
        t_flags           flags;
    } t_pitch_sb;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [ACC_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ACC_W-1:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/look_at_yaw_pitch_top.sv
// A word passes the difference register, the normalizer, the gain product register,
// the two CORDIC pipelines (one stage per iteration each) and the output register.
// Throughput: one word per cycle; busy stays low, every start is taken.
// Reset (synchronous, active low) clears the camera registers and all valid bits.
// Results cannot be held off; each shows on the output ports for one cycle.
module look_at_yaw_pitch_top
    import lay_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [COORD_W-1:0] i_target_x,
    input  logic signed [COORD_W-1:0] i_target_y,
    input  logic signed [COORD_W-1:0] i_target_z,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [COORD_W-1:0]       i_cfg_data,
    output logic                     o_valid,
    output logic [ANG_W-1:0]         o_pitch_angle,
    output logic [ANG_W-1:0]         o_yaw_angle,
    output logic                     o_zero_vector
);

    localparam int LAT = 2 * CORDIC_STEPS + 8;

    logic signed [COORD_W-1:0] r_cam_x, r_cam_y, r_cam_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAMERA_X: r_cam_x <= i_cfg_data;
                REG_CAMERA_Y: r_cam_y <= i_cfg_data;
                REG_CAMERA_Z: r_cam_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 0: exact differences and special-case flags
    logic signed [DIFF_W-1:0] n_dx, n_dy, n_dz, r_dx, r_dy, r_dz;
    t_flags                   n_f0, r_f0;
    logic                     r_v0;

    always_comb begin
        n_dx = DIFF_W'(i_target_x) - DIFF_W'(r_cam_x);
        n_dy = DIFF_W'(i_target_y) - DIFF_W'(r_cam_y);
        n_dz = DIFF_W'(i_target_z) - DIFF_W'(r_cam_z);
        n_f0.vert   = (n_dx == '0) && (n_dz == '0);
        n_f0.dy_pos = (n_dy > 0);
        n_f0.zero   = n_f0.vert && (n_dy == '0);
    end

    always_ff @(posedge i_clk) begin
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_dz <= n_dz;
        r_f0 <= n_f0;
    end

    logic                     nm_valid;
    logic signed [NORM_W-1:0] nm_dx, nm_dy, nm_dz;
    t_flags                   nm_flags;

    lay_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_dz    (r_dz),
        .i_flags (r_f0),
        .o_valid (nm_valid),
        .o_dx    (nm_dx),
        .o_dy    (nm_dy),
        .o_dz    (nm_dz),
        .o_flags (nm_flags)
    );

    // scale dy by the CORDIC gain so both pitch legs match
    logic signed [PROD_W-1:0] r_prod;
    logic signed [CRD_W-1:0]  r_mx, r_mz;
    t_flags                   r_fm;
    logic                     r_vm;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(nm_dy) * $signed({1'b0, GAIN_Q28});
        r_mx   <= CRD_W'(nm_dx);
        r_mz   <= CRD_W'(nm_dz);
        r_fm   <= nm_flags;
    end

    t_yaw_sb yaw_sb_in, yaw_sb_out;
    logic                    yaw_valid;
    logic signed [CRD_W-1:0] yaw_x;
    logic [ACC_W-1:0]        yaw_acc;

    assign yaw_sb_in.pitch_y = CRD_W'(r_prod >>> GAIN_SHIFT);
    assign yaw_sb_in.flags   = r_fm;

    lay_cordic #(.STEPS(CORDIC_STEPS), .SB_W($bits(t_yaw_sb))) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vm),
        .i_x     (r_mx),
        .i_y     (r_mz),
        .i_sb    (yaw_sb_in),
        .o_valid (yaw_valid),
        .o_x     (yaw_x),
        .o_acc   (yaw_acc),
        .o_sb    (yaw_sb_out)
    );

    t_pitch_sb pitch_sb_in, pitch_sb_out;
    logic                    pitch_valid;
    logic signed [CRD_W-1:0] pitch_x;
    logic [ACC_W-1:0]        pitch_acc;

    assign pitch_sb_in.yaw_acc = yaw_acc;
    assign pitch_sb_in.flags   = yaw_sb_out.flags;

    lay_cordic #(.STEPS(CORDIC_STEPS), .SB_W($bits(t_pitch_sb))) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (yaw_valid),
        .i_x     (yaw_x),
        .i_y     (yaw_sb_out.pitch_y),
        .i_sb    (pitch_sb_in),
        .o_valid (pitch_valid),
        .o_x     (pitch_x),
        .o_acc   (pitch_acc),
        .o_sb    (pitch_sb_out)
    );

    // output stage: round both angles, override the vertical cases
    logic [ACC_W-1:0] pitch_rnd, yaw_rnd;
    logic [ANG_W-1:0] n_pitch, n_yaw;
    logic             unused_x;

    assign unused_x = ^pitch_x;

    always_comb begin
        pitch_rnd = pitch_acc + ROUND_HALF;
        yaw_rnd   = pitch_sb_out.yaw_acc + ROUND_HALF;
        n_pitch   = pitch_rnd[ACC_W-1:ACC_W-ANG_W];
        n_yaw     = yaw_rnd[ACC_W-1:ACC_W-ANG_W] + TURN_3Q;
        if (pitch_sb_out.flags.vert) begin
            n_pitch = pitch_sb_out.flags.dy_pos ? TURN_1Q : TURN_3Q;
            n_yaw   = TURN_3Q;
        end
    end

    always_ff @(posedge i_clk) begin
        o_pitch_angle <= n_pitch;
        o_yaw_angle   <= n_yaw;
        o_zero_vector <= pitch_sb_out.flags.zero & ~unused_x | pitch_sb_out.flags.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_vm    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v0    <= start && !busy;
            r_vm    <= nm_valid;
            o_valid <= pitch_valid;
        end
    end

`ifndef ASSERT_OFF
    a_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_vector) |->
            (o_yaw_angle == TURN_3Q) && (o_pitch_angle == TURN_3Q))
        else $error("zero vector without vertical angles");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without a start LAT cycles back");

    a_vert_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pitch_valid && pitch_sb_out.flags.vert) |=> (o_yaw_angle == TURN_3Q))
        else $error("vertical word lost its yaw override");
`endif

endmodule

>>> rtl/lay_norm.sv
// Three-stage normalizer: scales the difference vector so its largest magnitude
// lands in [2^32, 2^33). Depends on lay_pkg.
module lay_norm
    import lay_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [DIFF_W-1:0] i_dx,
    input  logic signed [DIFF_W-1:0] i_dy,
    input  logic signed [DIFF_W-1:0] i_dz,
    input  t_flags                   i_flags,
    output logic                     o_valid,
    output logic signed [NORM_W-1:0] o_dx,
    output logic signed [NORM_W-1:0] o_dy,
    output logic signed [NORM_W-1:0] o_dz,
    output t_flags                   o_flags
);

    function automatic logic [COORD_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] a;
        a = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return a[COORD_W-1:0];
    endfunction

    logic [2:0] r_vld;

    // stage 1: magnitudes and maximum
    logic [COORD_W-1:0]       r_m1;
    logic signed [NORM_W-1:0] r_x1, r_y1, r_z1;
    t_flags                   r_f1;
    logic [COORD_W-1:0]       n_m1, ax, ay, az;

    always_comb begin
        ax = mag(i_dx);
        ay = mag(i_dy);
        az = mag(i_dz);
        n_m1 = ax;
        if (ay > n_m1) n_m1 = ay;
        if (az > n_m1) n_m1 = az;
    end

    always_ff @(posedge i_clk) begin
        r_m1 <= n_m1;
        r_x1 <= NORM_W'(i_dx);
        r_y1 <= NORM_W'(i_dy);
        r_z1 <= NORM_W'(i_dz);
        r_f1 <= i_flags;
    end

    // stage 2: coarse shifts by 16 and 8
    logic [COORD_W-1:0]       r_m2, n_m2;
    logic signed [NORM_W-1:0] r_x2, r_y2, r_z2, n_x2, n_y2, n_z2;
    t_flags                   r_f2;

    always_comb begin
        n_m2 = r_m1;
        n_x2 = r_x1;
        n_y2 = r_y1;
        n_z2 = r_z1;
        if (n_m2[31:16] == '0) begin
            n_m2 = n_m2 << 16;
            n_x2 = n_x2 <<< 16;
            n_y2 = n_y2 <<< 16;
            n_z2 = n_z2 <<< 16;
        end
        if (n_m2[31:24] == '0) begin
            n_m2 = n_m2 << 8;
            n_x2 = n_x2 <<< 8;
            n_y2 = n_y2 <<< 8;
            n_z2 = n_z2 <<< 8;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m2 <= n_m2;
        r_x2 <= n_x2;
        r_y2 <= n_y2;
        r_z2 <= n_z2;
        r_f2 <= r_f1;
    end

    // stage 3: fine shifts by 4, 2, 1, then one more to clear 2^32
    logic [COORD_W-1:0]       m3;
    logic signed [NORM_W-1:0] n_x3, n_y3, n_z3;

    always_comb begin
        m3 = r_m2;
        n_x3 = r_x2;
        n_y3 = r_y2;
        n_z3 = r_z2;
        if (m3[31:28] == '0) begin
            m3 = m3 << 4;
            n_x3 = n_x3 <<< 4;
            n_y3 = n_y3 <<< 4;
            n_z3 = n_z3 <<< 4;
        end
        if (m3[31:30] == '0) begin
            m3 = m3 << 2;
            n_x3 = n_x3 <<< 2;
            n_y3 = n_y3 <<< 2;
            n_z3 = n_z3 <<< 2;
        end
        if (m3[31] == 1'b0) begin
            n_x3 = n_x3 <<< 1;
            n_y3 = n_y3 <<< 1;
            n_z3 = n_z3 <<< 1;
        end
        n_x3 = n_x3 <<< 1;
        n_y3 = n_y3 <<< 1;
        n_z3 = n_z3 <<< 1;
    end

    always_ff @(posedge i_clk) begin
        o_dx    <= n_x3;
        o_dy    <= n_y3;
        o_dz    <= n_z3;
        o_flags <= r_f2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign o_valid = r_vld[2];

endmodule

>>> rtl/lay_cordic.sv
// Pipelined vectoring CORDIC: one register stage for the half-turn pre-rotation,
// then one stage per iteration. Carries a sideband word alongside. Depends on lay_pkg.
module lay_cordic
    import lay_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int SB_W  = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [CRD_W-1:0] i_x,
    input  logic signed [CRD_W-1:0] i_y,
    input  logic [SB_W-1:0]         i_sb,
    output logic                    o_valid,
    output logic signed [CRD_W-1:0] o_x,
    output logic [ACC_W-1:0]        o_acc,
    output logic [SB_W-1:0]         o_sb
);

    logic [STEPS:0]          r_vld;
    logic signed [CRD_W-1:0] r_x   [0:STEPS];
    logic signed [CRD_W-1:0] r_y   [0:STEPS];
    logic [ACC_W-1:0]        r_acc [0:STEPS];
    logic [SB_W-1:0]         r_sb  [0:STEPS];

    // fold the left half-plane onto the right
    always_ff @(posedge i_clk) begin
        if (i_x < 0) begin
            r_x[0]   <= -i_x;
            r_y[0]   <= -i_y;
            r_acc[0] <= TURN_HALF;
        end else begin
            r_x[0]   <= i_x;
            r_y[0]   <= i_y;
            r_acc[0] <= '0;
        end
        r_sb[0] <= i_sb;
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic signed [CRD_W-1:0] xs, ys;
        logic [ACC_W-1:0]        ang;
        assign xs  = r_x[g] >>> g;
        assign ys  = r_y[g] >>> g;
        assign ang = atan_turn(5'(g));

        always_ff @(posedge i_clk) begin
            if (r_y[g] > 0) begin
                r_x[g+1]   <= r_x[g] + ys;
                r_y[g+1]   <= r_y[g] - xs;
                r_acc[g+1] <= r_acc[g] + ang;
            end else begin
                r_x[g+1]   <= r_x[g] - ys;
                r_y[g+1]   <= r_y[g] + xs;
                r_acc[g+1] <= r_acc[g] - ang;
            end
            r_sb[g+1] <= r_sb[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STEPS-1:0], i_valid};
        end
    end

    assign o_valid = r_vld[STEPS];
    assign o_x     = r_x[STEPS];
    assign o_acc   = r_acc[STEPS];
    assign o_sb    = r_sb[STEPS];

endmodule

>>> tb/look_at_yaw_pitch_checker.sv
// Checker for the look-at angle block: watches the camera register writes,
// the start/busy handshake and the result strobe, predicts and compares.
// Depends on lay_pkg for widths and register indexes.
module look_at_yaw_pitch_checker
    import lay_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic signed [COORD_W-1:0] i_target_x,
    input  logic signed [COORD_W-1:0] i_target_y,
    input  logic signed [COORD_W-1:0] i_target_z,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [COORD_W-1:0]        i_cfg_data,
    input  logic                      i_valid,
    input  logic [ANG_W-1:0]          i_pitch_angle,
    input  logic [ANG_W-1:0]          i_yaw_angle,
    input  logic                      i_zero_vector,
    output int                        o_errors,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;

    typedef struct packed {
        logic [ANG_W-1:0] pitch;
        logic [ANG_W-1:0] yaw;
        logic             zero;
    } t_angles;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    logic signed [COORD_W-1:0] cam_x, cam_y, cam_z;
    t_angles angle_fifo[$];
    int errors;

    assign o_errors  = errors;
    assign o_pending = angle_fifo.size();

    // vectoring rotation; returns turn accumulator, final x in xo
    function automatic logic [31:0] rotate_to_axis(longint x, longint y,
                                                   output longint xo);
        logic [31:0] acc;
        longint xs, ys;
        acc = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = TURN_HALF;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                acc = acc + ATAN_TAB[i];
            end else begin
                x = x - ys;
                y = y + xs;
                acc = acc - ATAN_TAB[i];
            end
        end
        xo = x;
        return acc;
    endfunction

    function automatic t_angles look_angles(logic signed [31:0] tx, logic signed [31:0] ty,
                                            logic signed [31:0] tz);
        longint dx, dy, dz, m, hx, dummy;
        logic [31:0] yaw_acc, pitch_acc, r;
        t_angles a;
        dx = longint'(tx) - longint'(cam_x);
        dy = longint'(ty) - longint'(cam_y);
        dz = longint'(tz) - longint'(cam_z);
        if (dx == 0 && dz == 0) begin
            a.pitch = (dy > 0) ? TURN_1Q : TURN_3Q;
            a.yaw   = TURN_3Q;
            a.zero  = (dy == 0);
            return a;
        end
        m = (dx < 0) ? -dx : dx;
        if ((dy < 0 ? -dy : dy) > m) m = (dy < 0) ? -dy : dy;
        if ((dz < 0 ? -dz : dz) > m) m = (dz < 0) ? -dz : dz;
        while (m < 64'sd4294967296) begin
            m = m * 2;
            dx = dx * 2;
            dy = dy * 2;
            dz = dz * 2;
        end
        yaw_acc = rotate_to_axis(dx, dz, hx);
        pitch_acc = rotate_to_axis(hx, (dy * longint'(GAIN_Q28)) >>> GAIN_SHIFT, dummy);
        r = pitch_acc + ROUND_HALF;
        a.pitch = r[31:16];
        r = yaw_acc + ROUND_HALF;
        a.yaw = r[31:16] + TURN_3Q;
        a.zero = 1'b0;
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_angles want;
        if (!i_rst_n) begin
            cam_x <= '0;
            cam_y <= '0;
            cam_z <= '0;
            angle_fifo.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CAMERA_X: cam_x <= i_cfg_data;
                    REG_CAMERA_Y: cam_y <= i_cfg_data;
                    REG_CAMERA_Z: cam_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                angle_fifo.push_back(look_angles(i_target_x, i_target_y, i_target_z));
            if (i_valid) begin
                if (angle_fifo.size() == 0) begin
                    report_mismatch("result word with nothing expected", 1, 0);
                end else begin
                    want = angle_fifo.pop_front();
                    if (i_pitch_angle !== want.pitch)
                        report_mismatch("pitch_angle", i_pitch_angle, want.pitch);
                    if (i_yaw_angle !== want.yaw)
                        report_mismatch("yaw_angle", i_yaw_angle, want.yaw);
                    if (i_zero_vector !== want.zero)
                        report_mismatch("zero_vector", i_zero_vector, want.zero);
                end
            end
        end
    end

    initial errors = 0;

endmodule

>>> tb/look_at_yaw_pitch_top_test.sv
// Testbench top for look_at_yaw_pitch_top: clock, reset, camera writes and
// target words; checking lives in look_at_yaw_pitch_checker. Depends on lay_pkg.
module look_at_yaw_pitch_top_test;
    import lay_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 2 * 16 + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [COORD_W-1:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [COORD_W-1:0] i_cfg_data = '0;
    logic o_valid, o_zero_vector;
    logic [ANG_W-1:0] o_pitch_angle, o_yaw_angle;
    int errors, pending;
    int cycles = 0;
    logic signed [31:0] cx, cy, cz;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    look_at_yaw_pitch_top i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_target_x, .i_target_y, .i_target_z,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_valid, .o_pitch_angle, .o_yaw_angle,
        .o_zero_vector
    );

    look_at_yaw_pitch_checker i_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_target_x, .i_target_y,
        .i_target_z, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_valid(o_valid),
        .i_pitch_angle(o_pitch_angle), .i_yaw_angle(o_yaw_angle),
        .i_zero_vector(o_zero_vector), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("look_at_yaw_pitch_top verification failed");
            $finish;
        end
    end

    // drop start, let the pipe drain, then hold for its depth
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // write one register, then drop the enable and wait with it low
    task automatic write_camera(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_camera(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        drain_pipe();
        write_camera(REG_CAMERA_X, x);
        write_camera(REG_CAMERA_Y, y);
        write_camera(REG_CAMERA_Z, z);
        cx = x;
        cy = y;
        cz = z;
    endtask

    // start stays high after a word; only an idle gap or drain_pipe lowers it
    task automatic send_word(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_target_x <= x;
        i_target_y <= y;
        i_target_z <= z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] c);
        case ($urandom_range(5))
            0: return c;
            1: return c + $signed($urandom_range(8)) - 4;
            2: return c + ($signed($urandom) >>> $urandom_range(31));
            3: return $urandom_range(1) ? S_MAX : S_MIN;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_words(int n, int idle_pct);
        logic signed [31:0] x, y, z;
        for (int i = 0; i < n; i++) begin
            x = near(cx);
            y = near(cy);
            z = near(cz);
            // keep vertical and zero directions frequent
            if ($urandom_range(9) == 0) begin
                x = cx;
                z = cz;
            end
            send_word(x, y, z, idle_pct);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cx = '0;
        cy = '0;
        cz = '0;
        @(posedge i_clk);

        // directed: zero, vertical, axes and extreme spans
        send_word(0, 0, 0, 0);
        send_word(0, 5, 0, 0);
        send_word(0, -5, 0, 0);
        send_word(S_MAX, 0, 0, 0);
        send_word(S_MIN, 0, 0, 0);
        send_word(0, 0, S_MAX, 0);
        send_word(0, 0, S_MIN, 0);
        send_word(1, 1, 1, 0);
        send_word(-1, -1, -1, 0);
        send_word(S_MAX, S_MAX, S_MAX, 0);
        send_word(S_MIN, S_MIN, S_MIN, 0);
        send_word(-3, 7, 0, 0);
        send_word(-1, 0, 1, 0);
        set_camera(S_MIN, S_MIN, S_MIN);
        send_word(S_MAX, S_MAX, S_MAX, 0);
        send_word(S_MIN, S_MAX, S_MIN, 0);
        send_word(S_MIN, S_MIN, S_MIN, 0);
        set_camera(S_MAX, S_MAX, S_MAX);
        send_word(S_MIN, S_MIN, S_MIN, 0);
        send_word(S_MAX, S_MIN, S_MAX, 0);
        send_word(S_MAX, S_MAX, S_MAX, 0);
        // unmapped index must leave the camera alone
        drain_pipe();
        write_camera(REG_UNMAPPED, 32'h1234_5678);
        send_word(S_MAX, S_MAX, S_MAX, 0);
        send_word(S_MIN, 0, S_MAX, 0);

        set_camera($urandom, $urandom, $urandom);
        random_words(250, 0);
        set_camera(0, 0, 0);
        random_words(250, 84);
        // sender holds until every result is back
        drain_pipe();
        random_words(50, 0);
        set_camera(S_MIN, S_MAX, S_MIN);
        random_words(250, 17);
        set_camera($urandom, $urandom, $urandom);
        random_words(250, 84);
        set_camera(S_MAX, S_MIN, S_MAX);
        random_words(250, 0);

        drain_pipe();
        if (errors == 0)
            $display("look_at_yaw_pitch_top verification clean");
        else
            $display("look_at_yaw_pitch_top verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/lay_pkg.sv
rtl/lay_norm.sv
rtl/lay_cordic.sv
rtl/look_at_yaw_pitch_top.sv
tb/look_at_yaw_pitch_checker.sv
tb/look_at_yaw_pitch_top_test.sv
